FILE: hw/rtl/tbe_pkg.sv
package tbe_pkg;
  localparam int SampleW = 24;
  localparam int StageW = 32;
  localparam int CoefW = 18;
  localparam int GainW = 16;
  localparam int CfgW = 18;
  localparam int FracShift = StageW - SampleW;
  // serial product accumulator width: stage value times 18-bit multiplier
  localparam int AccW = StageW + CoefW + 2;
  localparam int CntW = 5;

  localparam logic [2:0] REG_LOW_COEFF = 3'd0;
  localparam logic [2:0] REG_HIGH_COEFF = 3'd1;
  localparam logic [2:0] REG_LOW_GAIN = 3'd2;
  localparam logic [2:0] REG_MID_GAIN = 3'd3;
  localparam logic [2:0] REG_HIGH_GAIN = 3'd4;
  localparam logic [2:0] REG_ENABLE = 3'd5;

  typedef logic signed [StageW-1:0] stage_t;
endpackage

FILE: hw/rtl/three_band_equalizer.sv
// Bypass: out_valid is registered on the accepting edge. Filtering: 11
// serial products, each with load, a shift-add per multiplier bit, done and
// update; the filter path takes no next beat until its pass has ended,
// since every product goes through the shared bit-serial multiplier.
// One beat at a time. Output register frees on out_ready. Reset (rst_n,
// synchronous, low) clears stages, history and restores register defaults.
module three_band_equalizer
  import tbe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SampleW-1:0] in_sample_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SampleW-1:0] out_sample_out,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [CfgW-1:0]           cfg_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_UPD = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  localparam logic signed [AccW-1:0] StMax = AccW'({1'b0, {(StageW-1){1'b1}}});
  localparam logic signed [AccW-1:0] StMin = -StMax - 1;
  localparam logic signed [AccW-1:0] SmMax = AccW'({1'b0, {(SampleW-1){1'b1}}});
  localparam logic signed [AccW-1:0] SmMin = -SmMax - 1;

  logic [CoefW-1:0] low_coeff_r, high_coeff_r;
  logic [GainW-1:0] low_gain_r, mid_gain_r, high_gain_r;
  logic enable_r;

  stage_t low_st_r [4];
  stage_t high_st_r [4];
  logic signed [SampleW-1:0] hist_r [3];
  logic signed [SampleW-1:0] x_r;
  logic [2:0] state_r;
  // step 0..7: cascade stages (low 0-3, high 4-7); 8..10: band gains
  logic [3:0] step_r;
  logic signed [AccW-1:0] sum_r;
  logic signed [SampleW-1:0] out_r;
  logic out_valid_r;
  logic out_set;

  logic mul_start, mul_done;
  logic signed [AccW-1:0] mcand, prod, delta, upd, band, xs, d;
  logic [CoefW-1:0] mplier;
  stage_t prev_x;

  assign xs = AccW'(x_r) <<< FracShift;
  assign d = AccW'(hist_r[2]) <<< FracShift;

  always_comb begin
    prev_x = stage_t'(xs);
    band = '0;
    mcand = '0;
    mplier = '0;
    if (step_r < 4'd4) begin
      if (step_r != 4'd0) prev_x = low_st_r[step_r[1:0] - 2'd1];
      mcand = AccW'(prev_x) - AccW'(low_st_r[step_r[1:0]]);
      mplier = low_coeff_r;
    end else if (step_r < 4'd8) begin
      if (step_r != 4'd4) prev_x = high_st_r[step_r[1:0] - 2'd1];
      mcand = AccW'(prev_x) - AccW'(high_st_r[step_r[1:0]]);
      mplier = high_coeff_r;
    end else begin
      case (step_r)
        4'd8: begin
          band = AccW'(low_st_r[3]);
          mplier = CoefW'(low_gain_r);
        end
        4'd9: begin
          band = d - (d - AccW'(high_st_r[3])) - AccW'(low_st_r[3]);
          mplier = CoefW'(mid_gain_r);
        end
        default: begin
          band = d - AccW'(high_st_r[3]);
          mplier = CoefW'(high_gain_r);
        end
      endcase
      mcand = band;
    end
  end

  assign mul_start = (state_r == ST_MUL);
  tbe_sermul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .mcand(mcand),
    .mplier(mplier), .done(mul_done), .prod(prod)
  );

  always_comb begin
    if (step_r < 4'd8) delta = prod >>> 16;
    else delta = prod >>> 12;
    upd = AccW'(step_r < 4'd4 ? low_st_r[step_r[1:0]] : high_st_r[step_r[1:0]])
          + delta;
    if (upd > StMax) upd = StMax;
    else if (upd < StMin) upd = StMin;
  end

  logic signed [AccW-1:0] ysh;
  assign ysh = sum_r >>> FracShift;

  // load a result: a bypassed beat on accept, or a finished filter pass
  assign out_set = ((state_r == ST_IDLE) && in_valid && in_ready && !enable_r) ||
                   ((state_r == ST_OUT) && !out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_coeff_r <= CoefW'(7469);
      high_coeff_r <= CoefW'(45962);
      low_gain_r <= GainW'(4096);
      mid_gain_r <= GainW'(4096);
      high_gain_r <= GainW'(4096);
      enable_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        low_st_r[i] <= '0;
        high_st_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) hist_r[i] <= '0;
      state_r <= ST_IDLE;
      step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_COEFF: low_coeff_r <= cfg_data;
          REG_HIGH_COEFF: high_coeff_r <= cfg_data;
          REG_LOW_GAIN: low_gain_r <= cfg_data[GainW-1:0];
          REG_MID_GAIN: mid_gain_r <= cfg_data[GainW-1:0];
          REG_HIGH_GAIN: high_gain_r <= cfg_data[GainW-1:0];
          REG_ENABLE: enable_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_set) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            x_r <= in_sample_in;
            if (enable_r) begin
              step_r <= '0;
              sum_r <= '0;
              state_r <= ST_MUL;
            end else begin
              out_r <= in_sample_in;
            end
          end
        end
        ST_MUL: state_r <= ST_WAIT;
        ST_WAIT: if (mul_done) state_r <= ST_UPD;
        ST_UPD: begin
          // advance one stage or accumulate one band
          if (step_r < 4'd4) low_st_r[step_r[1:0]] <= stage_t'(upd);
          else if (step_r < 4'd8) high_st_r[step_r[1:0]] <= stage_t'(upd);
          else sum_r <= sum_r + delta;
          if (step_r == 4'd10) state_r <= ST_OUT;
          else begin
            step_r <= step_r + 4'd1;
            state_r <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (!out_valid_r) begin
            if (ysh > SmMax) out_r <= SmMax[SampleW-1:0];
            else if (ysh < SmMin) out_r <= SmMin[SampleW-1:0];
            else out_r <= ysh[SampleW-1:0];
            hist_r[2] <= hist_r[1];
            hist_r[1] <= hist_r[0];
            hist_r[0] <= x_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // hold new beats while a result waits unless it is being taken
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_sample_out = out_r;
endmodule

FILE: hw/rtl/tbe_sermul.sv
// Shift-and-add multiplier: signed value times unsigned multiplier,
// one multiplier bit per cycle, LSB first.
module tbe_sermul
  import tbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [AccW-1:0] mcand,
  input  logic [CoefW-1:0]       mplier,
  output logic                   done,
  output logic signed [AccW-1:0] prod
);
  logic signed [AccW-1:0] acc_r, acc_nxt;
  logic signed [AccW-1:0] mc_r, mc_nxt;
  logic [CoefW-1:0] mp_r, mp_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mp_nxt = mp_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = mcand;
      mp_nxt = mplier;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt = mc_r <<< 1;
      mp_nxt = mp_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(CoefW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mp_r <= mp_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
